>>> sv/rhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rhc_pkg;

	// Channel code width
	localparam int CHAN_W = 8;
	// Width of the hue dividend and divisor (6 * 255 fits in 11 bits)
	localparam int DIV_W = 11;
	// Default output precisions
	localparam int HUE_BITS_DEF = 16;
	localparam int SAT_FRAC_BITS_DEF = 16;
	// Depth of the queue between classifier and divider pipeline
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// One classified pixel, as handed from the front end to the dividers
	typedef struct packed {
		logic              dz;     // max equals min: hue and saturation are zero
		logic [DIV_W-1:0]  n;      // hue dividend, below d6 unless dz is set
		logic [DIV_W-1:0]  d6;     // hue divisor, six times the spread
		logic [CHAN_W-1:0] d;      // spread between largest and smallest channel
		logic [CHAN_W-1:0] mx;     // largest channel
		logic [CHAN_W-1:0] alpha;
	} cls_t;

endpackage
`default_nettype wire

>>> sv/rhc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// RGBA pixel beat
interface rhc_pix_if;
	logic                      valid;
	logic                      ready;
	logic [rhc_pkg::CHAN_W-1:0] red;
	logic [rhc_pkg::CHAN_W-1:0] green;
	logic [rhc_pkg::CHAN_W-1:0] blue;
	logic [rhc_pkg::CHAN_W-1:0] alpha;

	modport source(output valid, red, green, blue, alpha, input ready);
	modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

// HSV pixel beat
interface rhc_hsv_if #(
	parameter int HUE_BITS      = rhc_pkg::HUE_BITS_DEF,
	parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [HUE_BITS-1:0]        hue;
	logic [SAT_FRAC_BITS:0]     saturation;
	logic [rhc_pkg::CHAN_W-1:0] value;
	logic [rhc_pkg::CHAN_W-1:0] alpha_out;

	modport source(output valid, hue, saturation, value, alpha_out, input ready);
	modport sink(input valid, hue, saturation, value, alpha_out, output ready);
endinterface
`default_nettype wire

>>> sv/rhc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rhc_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	rhc_pix_if.sink           pix,
	output rhc_pkg::cls_t     ent,
	output logic              ent_valid,
	input  wire logic         ent_ready
);

	logic                       red_max;
	logic                       grn_max;
	logic [rhc_pkg::CHAN_W-1:0] mx;
	logic [rhc_pkg::CHAN_W-1:0] mn;
	logic [rhc_pkg::CHAN_W-1:0] d;
	logic [rhc_pkg::CHAN_W-1:0] diff;
	logic [rhc_pkg::DIV_W-1:0]  d_w;
	logic [rhc_pkg::DIV_W-1:0]  d6;
	logic [rhc_pkg::DIV_W-1:0]  n;
	rhc_pkg::cls_t              cls;
	rhc_pkg::cls_t              ent_s1;
	logic                       vld_s1;
	logic                       take;

	// Pick largest and smallest channel; red wins ties, then green
	always_comb begin
		red_max = (pix.red >= pix.green) && (pix.red >= pix.blue);
		grn_max = !red_max && (pix.green >= pix.blue);
		if (red_max) begin
			mx = pix.red;
		end else if (grn_max) begin
			mx = pix.green;
		end else begin
			mx = pix.blue;
		end
		mn = pix.red;
		if (pix.green < mn) begin
			mn = pix.green;
		end
		if (pix.blue < mn) begin
			mn = pix.blue;
		end
		d   = mx - mn;
		d_w = {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, d};
		d6  = (d_w << 2) + (d_w << 1);
	end

	// Build the hue dividend for the winning sector
	always_comb begin
		diff = '0;
		if (red_max) begin
			if (pix.green >= pix.blue) begin
				diff = pix.green - pix.blue;
				n    = {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, diff};
			end else begin
				diff = pix.blue - pix.green;
				n    = d6 - {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, diff};
			end
		end else if (grn_max) begin
			n = {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, pix.blue}
				+ (d_w << 1)
				- {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, pix.red};
		end else begin
			n = {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, pix.red}
				+ (d_w << 2)
				- {{(rhc_pkg::DIV_W-rhc_pkg::CHAN_W){1'b0}}, pix.green};
		end
	end

	always_comb begin
		cls.dz    = (d == '0);
		cls.n     = n;
		cls.d6    = d6;
		cls.d     = d;
		cls.mx    = mx;
		cls.alpha = pix.alpha;
	end

	// Hold the classified beat until the queue takes it
	assign take      = !vld_s1 || ent_ready;
	assign pix.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pix.valid) begin
			ent_s1 <= cls;
		end
	end

	assign ent       = ent_s1;
	assign ent_valid = vld_s1;

endmodule
`default_nettype wire

>>> sv/rhc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rhc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rhc_pkg::cls_t wr_data,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output rhc_pkg::cls_t      rd_data,
	output logic               rd_valid,
	input  wire logic          rd_ready
);

	rhc_pkg::cls_t          mem_q [rhc_pkg::QDEPTH];
	logic [rhc_pkg::QAW-1:0] wr_ptr_q;
	logic [rhc_pkg::QAW-1:0] rd_ptr_q;
	logic [rhc_pkg::QAW:0]   cnt_q;
	logic                    push;
	logic                    pop;

	assign wr_ready = (cnt_q != (rhc_pkg::QAW+1)'(rhc_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

>>> sv/rhc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rhc_back #(
	parameter int HUE_BITS      = rhc_pkg::HUE_BITS_DEF,
	parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rhc_pkg::cls_t in_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	rhc_hsv_if.source          hsv
);

	localparam int SAT_BITS = SAT_FRAC_BITS + 1;
	localparam int NSTG     = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

	typedef struct packed {
		logic                       dz;
		logic [rhc_pkg::DIV_W-1:0]  hrem;
		logic [rhc_pkg::DIV_W-1:0]  hd;
		logic [HUE_BITS-1:0]        hq;
		logic [rhc_pkg::CHAN_W-1:0] srem;
		logic [rhc_pkg::CHAN_W-1:0] smx;
		logic [SAT_BITS-1:0]        sq;
		logic [rhc_pkg::CHAN_W-1:0] alpha;
	} stg_t;

	stg_t            stg_s [NSTG];
	logic [NSTG-1:0] vld_s;
	logic            en;

	// Whole pipeline moves unless the output beat is stuck
	assign en       = !vld_s[NSTG-1] || hsv.ready;
	assign in_ready = en;

	for (genvar gi = 0; gi < NSTG; gi++) begin : g_stg
		stg_t                       src;
		stg_t                       nxt;
		logic                       src_v;
		logic [rhc_pkg::DIV_W:0]    ht;
		logic [rhc_pkg::DIV_W:0]    hsub;
		logic                       hge;
		logic [rhc_pkg::CHAN_W:0]   st;
		logic [rhc_pkg::CHAN_W:0]   ssub;
		logic                       sge;

		if (gi == 0) begin : g_head
			always_comb begin
				src.dz    = in_data.dz;
				src.hrem  = in_data.n;
				src.hd    = in_data.d6;
				src.hq    = '0;
				src.srem  = in_data.d;
				src.smx   = in_data.mx;
				src.sq    = '0;
				src.alpha = in_data.alpha;
			end
			assign src_v = in_valid;
		end else begin : g_tail
			assign src   = stg_s[gi-1];
			assign src_v = vld_s[gi-1];
		end

		// One restoring step of each divider that still has quotient bits to produce
		always_comb begin
			nxt  = src;
			ht   = {src.hrem, 1'b0};
			hsub = ht - {1'b0, src.hd};
			hge  = (ht >= {1'b0, src.hd});
			if (gi == 0) begin
				st = {1'b0, src.srem};
			end else begin
				st = {src.srem, 1'b0};
			end
			ssub = st - {1'b0, src.smx};
			sge  = (st >= {1'b0, src.smx});
			if (gi < HUE_BITS) begin
				nxt.hrem = hge ? hsub[rhc_pkg::DIV_W-1:0] : ht[rhc_pkg::DIV_W-1:0];
				nxt.hq   = {src.hq[HUE_BITS-2:0], hge};
			end
			if (gi < SAT_BITS) begin
				nxt.srem = sge ? ssub[rhc_pkg::CHAN_W-1:0] : st[rhc_pkg::CHAN_W-1:0];
				nxt.sq   = {src.sq[SAT_BITS-2:0], sge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en && src_v) begin
				stg_s[gi] <= nxt;
			end
		end
	end

	// Drive the result beat; flat pixels get zero hue and saturation
	assign hsv.valid      = vld_s[NSTG-1];
	assign hsv.hue        = stg_s[NSTG-1].dz ? '0 : stg_s[NSTG-1].hq;
	assign hsv.saturation = stg_s[NSTG-1].dz ? '0 : stg_s[NSTG-1].sq;
	assign hsv.value      = stg_s[NSTG-1].smx;
	assign hsv.alpha_out  = stg_s[NSTG-1].alpha;

endmodule
`default_nettype wire

>>> sv/rgb_to_hsv_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// RGBA to HSV converter. Takes one pixel per clock on pix while hsv is
// ready and returns, in order, value (largest channel), saturation
// ((max-min)/max as unsigned Q1.SAT_FRAC_BITS, truncated) and hue (unsigned
// Q0.HUE_BITS fraction of a turn, truncated; red wins ties for largest, then
// green), with alpha passed through. Flat pixels (all channels equal, black
// included) give zero hue and zero saturation. Throughput is one pixel per
// clock when hsv is ready. A pix beat passes the classifier register, the
// queue and one divider pipeline stage per quotient bit of the longer of the
// two restoring dividers on its way to hsv. A four-entry queue sits between
// the classifier and the dividers.
module rgb_to_hsv_convert #(
	parameter int HUE_BITS      = rhc_pkg::HUE_BITS_DEF,
	parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rhc_pix_if.sink   pix,
	rhc_hsv_if.source hsv
);

	rhc_pkg::cls_t fe_data;
	logic          fe_valid;
	logic          fe_ready;
	rhc_pkg::cls_t be_data;
	logic          be_valid;
	logic          be_ready;

	rhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.ent      (fe_data),
		.ent_valid(fe_valid),
		.ent_ready(fe_ready)
	);

	rhc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (fe_data),
		.wr_valid(fe_valid),
		.wr_ready(fe_ready),
		.rd_data (be_data),
		.rd_valid(be_valid),
		.rd_ready(be_ready)
	);

	rhc_back #(
		.HUE_BITS     (HUE_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (be_data),
		.in_valid(be_valid),
		.in_ready(be_ready),
		.hsv     (hsv)
	);

endmodule
`default_nettype wire

>>> tb/rgb_to_hsv_convert_tb.sv
`timescale 1ns / 1ps
module rgb_to_hsv_convert_tb;

	localparam int HUE_W        = rhc_pkg::HUE_BITS_DEF;
	localparam int SAT_W        = rhc_pkg::SAT_FRAC_BITS_DEF;
	localparam int RESET_CYCLES = 5;
	localparam int RAND_ITEMS   = 1300;
	// tail covers the classifier register, the queue and the divider stages, with margin
	localparam int TAIL_CYCLES  = 2 * (2 + ((HUE_W > SAT_W + 1) ? HUE_W : SAT_W + 1));
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 40;
	localparam int NUM_DIR      = 18;

	typedef struct packed {
		logic [HUE_W-1:0]           hue;
		logic [SAT_W:0]             saturation;
		logic [rhc_pkg::CHAN_W-1:0] value;
		logic [rhc_pkg::CHAN_W-1:0] alpha_out;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       known;
		hsv_t       hsv;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rhc_pix_if pix_bus ();
	rhc_hsv_if #(.HUE_BITS(HUE_W), .SAT_FRAC_BITS(SAT_W)) hsv_bus ();

	rgb_to_hsv_convert #(
		.HUE_BITS(HUE_W),
		.SAT_FRAC_BITS(SAT_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_bus.sink),
		.hsv(hsv_bus.source)
	);

	hsv_t        hsv_expected_q[$];
	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;
	logic        idle_on     = 1'b1;

	// Directed pixels: extremes, primaries, greys and ties for the largest channel
	dir_row_t dir_table [NUM_DIR] = '{
		'{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     17'd0,     8'd0,   8'd0}},
		'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     17'd0,     8'd255, 8'd255}},
		'{8'd128, 8'd128, 8'd128, 8'h5A,  1'b1, '{16'd0,     17'd0,     8'd128, 8'h5A}},
		'{8'd255, 8'd0,   8'd0,   8'd255, 1'b1, '{16'd0,     17'd65536, 8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd0,   8'd0,   1'b1, '{16'd21845, 17'd65536, 8'd255, 8'd0}},
		'{8'd0,   8'd0,   8'd255, 8'hA5,  1'b1, '{16'd43690, 17'd65536, 8'd255, 8'hA5}},
		'{8'd1,   8'd1,   8'd1,   8'h01,  1'b1, '{16'd0,     17'd0,     8'd1,   8'h01}},
		'{8'd255, 8'd255, 8'd0,   8'h3C,  1'b0, '0},
		'{8'd255, 8'd0,   8'd255, 8'hC3,  1'b0, '0},
		'{8'd0,   8'd255, 8'd255, 8'h80,  1'b0, '0},
		'{8'd255, 8'd0,   8'd1,   8'h7F,  1'b0, '0},
		'{8'd1,   8'd0,   8'd0,   8'hFE,  1'b0, '0},
		'{8'd0,   8'd0,   8'd1,   8'h55,  1'b0, '0},
		'{8'd254, 8'd255, 8'd255, 8'hAA,  1'b0, '0},
		'{8'd1,   8'd2,   8'd3,   8'h0F,  1'b0, '0},
		'{8'd200, 8'd100, 8'd150, 8'hF0,  1'b0, '0},
		'{8'd10,  8'd250, 8'd30,  8'h33,  1'b0, '0},
		'{8'd255, 8'd254, 8'd253, 8'hCC,  1'b0, '0}
	};

	// Free-running clock
	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Compute the HSV beat expected for one RGBA beat
	function automatic hsv_t hsv_of(input logic [7:0] r, g, b, a);
		int unsigned mx, mn, d, n;
		hsv_t res;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		res = '0;
		res.value = mx[7:0];
		res.alpha_out = a;
		if (mx != 0) begin
			res.saturation = (SAT_W + 1)'((d << SAT_W) / mx);
			if (d != 0) begin
				// red wins ties, then green
				if (mx == r)
					n = (g >= b) ? (g - b) : (g + 6 * d - b);
				else if (mx == g)
					n = b + 2 * d - r;
				else
					n = r + 4 * d - g;
				res.hue = HUE_W'((longint'(n) << HUE_W) / (6 * d));
			end
		end
		return res;
	endfunction

	function automatic logic [7:0] pick_extreme_code();
		case ($urandom_range(0, 2))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int unsigned draw_wait();
		return idle_on ? $urandom_range(0, 7) : 0;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Compare one received beat against the oldest expectation
	task automatic check_pixel(input hsv_t got);
		hsv_t want;
		if (hsv_expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected beat hue=%0d sat=%0d value=%0d alpha=%0d",
				got.hue, got.saturation, got.value, got.alpha_out));
			return;
		end
		want = hsv_expected_q.pop_front();
		if (got.hue !== want.hue)
			report_mismatch($sformatf("hue got %0d want %0d", got.hue, want.hue));
		if (got.saturation !== want.saturation)
			report_mismatch($sformatf("saturation got %0d want %0d",
				got.saturation, want.saturation));
		if (got.value !== want.value)
			report_mismatch($sformatf("value got %0d want %0d", got.value, want.value));
		if (got.alpha_out !== want.alpha_out)
			report_mismatch($sformatf("alpha_out got %0d want %0d",
				got.alpha_out, want.alpha_out));
	endtask

	// Drive one pixel beat after a random gap; hold it until accepted
	task automatic send_pixel(input logic [7:0] r, g, b, a, input hsv_t want);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			pix_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.red   <= r;
		pix_bus.green <= g;
		pix_bus.blue  <= b;
		pix_bus.alpha <= a;
		do @(posedge clk); while (pix_bus.ready !== 1'b1);
		hsv_expected_q = {hsv_expected_q, want};
	endtask

	// Hold the input idle until every pending result is back
	task automatic drain_results();
		pix_bus.valid <= 1'b0;
		do @(posedge clk); while (hsv_expected_q.size() != 0);
	endtask

	// Result side: stall at random, then take and check one beat
	initial begin : hsv_sink
		int unsigned stall;
		hsv_t got;
		hsv_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				hsv_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hsv_bus.ready <= 1'b1;
			do @(posedge clk); while (hsv_bus.valid !== 1'b1);
			got.hue        = hsv_bus.hue;
			got.saturation = hsv_bus.saturation;
			got.value      = hsv_bus.value;
			got.alpha_out  = hsv_bus.alpha_out;
			check_pixel(got);
		end
	end

	// Pixel side: reset, directed table, then random pixels
	initial begin : pix_source
		dir_row_t row;
		logic [7:0] r, g, b, a, hi;
		int k;
		arst_n        = 1'b0;
		pix_bus.valid = 1'b0;
		pix_bus.red   = '0;
		pix_bus.green = '0;
		pix_bus.blue  = '0;
		pix_bus.alpha = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (k = 0; k < NUM_DIR; k++) begin
			row = dir_table[k];
			send_pixel(row.red, row.green, row.blue, row.alpha,
				row.known ? row.hsv : hsv_of(row.red, row.green, row.blue, row.alpha));
		end
		drain_results();

		// random pixels, biased toward greys, ties, extremes and near-flat colors
		for (k = 0; k < RAND_ITEMS; k++) begin
			if (k % 64 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (k == RAND_ITEMS / 2)
				drain_results();
			hi = 8'($urandom_range(0, 255));
			a  = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0: begin
					r = hi;
					g = hi;
					b = hi;
				end
				1: begin
					r = hi;
					g = hi;
					b = 8'($urandom_range(0, hi));
					case ($urandom_range(0, 2))
						0: ;
						1: {g, b} = {b, g};
						default: {r, b} = {b, r};
					endcase
				end
				2: begin
					r = pick_extreme_code();
					g = pick_extreme_code();
					b = pick_extreme_code();
				end
				3: begin
					r = hi ^ 8'($urandom_range(0, 3));
					g = hi ^ 8'($urandom_range(0, 3));
					b = hi ^ 8'($urandom_range(0, 3));
				end
				default: begin
					r = 8'($urandom_range(0, 255));
					g = 8'($urandom_range(0, 255));
					b = 8'($urandom_range(0, 255));
				end
			endcase
			send_pixel(r, g, b, a, hsv_of(r, g, b, a));
		end
		pix_bus.valid <= 1'b0;

		// wait out the pipeline, then look for stray beats
		while (hsv_expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
